>>> rtl/dfir_pkg.sv
// Shared types and constants for the decimating FIR filter.
// No dependencies; every other file in rtl/ imports this package.
package dfir_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int CIDX_W    = 8;
    localparam int OUT_W     = 25;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int REQ_W     = 2;
    localparam int FRAC_W    = 17;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 25'sh0FFFFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 25'sh1000000;

    typedef enum logic [REQ_W-1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_COEF   = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAP_COUNT  = 1'b0,
        CFG_DECIMATION = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_ROTATE,
        CM_SHIFT,
        CM_CLEAR
    } cell_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clr;
        logic vld;
    } mac_ctl_t;

endpackage

>>> rtl/dfir_cell.sv
// One history cell: holds a sample, shifts in from the left, rotates from the right, or clears.
// Depends on dfir_pkg.
module dfir_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dfir_pkg::cell_mode_t                 mode,
    input  logic signed [dfir_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [dfir_pkg::SAMPLE_W-1:0] right_in,
    output logic signed [dfir_pkg::SAMPLE_W-1:0] q
);
    import dfir_pkg::*;

    logic signed [SAMPLE_W-1:0] q_reg;
    logic signed [SAMPLE_W-1:0] q_next;

    always_comb
    begin
        case (mode)
            CM_HOLD:   q_next = q_reg;
            CM_ROTATE: q_next = right_in;
            CM_SHIFT:  q_next = left_in;
            CM_CLEAR:  q_next = '0;
            default:   q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

>>> rtl/dfir_coef_ram.sv
// Coefficient store: one write port, one read port with registered data.
// Depends on dfir_pkg.
module dfir_coef_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                               clk,
    input  logic                               we,
    input  logic [AW-1:0]                      waddr,
    input  logic signed [dfir_pkg::COEF_W-1:0] wdata,
    input  logic [AW-1:0]                      raddr,
    output logic signed [dfir_pkg::COEF_W-1:0] rdata
);
    import dfir_pkg::*;

    logic signed [COEF_W-1:0] mem [DEPTH];
    logic signed [COEF_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/dfir_mac.sv
// Pipelined multiply-accumulate with round-half-up by 2^17 and 25-bit saturation.
// Depends on dfir_pkg.
module dfir_mac #(
    parameter int ACC_W = 43
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dfir_pkg::mac_ctl_t                   ctl,
    input  logic signed [dfir_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [dfir_pkg::COEF_W-1:0]   coef,
    output logic signed [dfir_pkg::OUT_W-1:0]    result
);
    import dfir_pkg::*;

    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int SH_W   = ACC_W - FRAC_W;

    logic signed [SAMPLE_W-1:0] samp_reg;
    logic                       v1_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       v2_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [ACC_W-1:0]    rnd;
    logic signed [SH_W-1:0]     shifted;

    // stage 1 lines the sample up with the registered RAM read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (ctl.clr)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.vld;
            v2_reg <= v1_reg;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clr)
        begin
            acc_next = '0;
        end
        else if (v2_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg <= sample;
        prod_reg <= samp_reg * coef;
        acc_reg  <= acc_next;
    end

    assign rnd     = acc_reg + (ACC_W'(1) <<< (FRAC_W - 1));
    assign shifted = rnd[ACC_W-1:FRAC_W];

    always_comb
    begin
        if (shifted > SH_W'(OUT_MAX))
        begin
            result = OUT_MAX;
        end
        else if (shifted < SH_W'(OUT_MIN))
        begin
            result = OUT_MIN;
        end
        else
        begin
            result = shifted[OUT_W-1:0];
        end
    end

endmodule

>>> rtl/decimating_fir_filter_top.sv
// Decimating FIR filter top level: history cell chain, coefficient RAM, MAC, control.
// Depends on dfir_pkg, dfir_cell, dfir_coef_ram, dfir_mac.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tuser: req_type; tdata: sample, coef_index, coef_value
//  m_*     | out | m_tvalid/m_tready  | tdata: filtered
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (tap_count, decimation)
//
// A coefficient write, a clear, or a sample that gives no output is handled in the idle state.
// A sample that gives an output is accepted, then the MAC state does one MAC per
// cycle while the history chain makes a full rotation past cell 0, then the drain state
// empties the pipeline and the finish state loads the rounded result.
// The output sits in a register; the next item is taken while it waits, and a new
// output is held back only while that register is still full. Reset clears history, phase,
// state and valid flag (tap_count = decimation = 1); coefficients are undefined until written.
module decimating_fir_filter_top #(
    parameter int MAX_TAPS       = 256,
    parameter int MAX_DECIMATION = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // sample[15:0], coef_index[23:16], coef_value[41:24], zero
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // filtered[24:0], zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [dfir_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dfir_pkg::CFG_W-1:0]     cfg_data
);
    import dfir_pkg::*;

    localparam int D     = MAX_TAPS - 1;
    localparam int AW    = $clog2(MAX_TAPS);
    localparam int TW    = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam int IW    = (AW + 1 > CIDX_W) ? AW + 1 : CIDX_W;
    localparam int PW    = (MAX_DECIMATION > 1) ? $clog2(MAX_DECIMATION) : 1;
    localparam int DW0   = $clog2(MAX_DECIMATION + 1);
    localparam int DW    = (DW0 > CFG_W) ? DW0 : CFG_W;
    localparam int ACC_W = (35 + AW > 43) ? 35 + AW : 43;

    // payload fields
    logic [REQ_W-1:0]           req_type;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CIDX_W-1:0]          coef_index;
    logic signed [COEF_W-1:0]   coef_value;

    assign req_type   = s_tuser;
    assign sample     = s_tdata[15:0];
    assign coef_index = s_tdata[23:16];
    assign coef_value = s_tdata[41:24];

    state_t                     state_reg, state_next;
    logic [AW-1:0]              cnt_reg, cnt_next;
    logic [CFG_W-1:0]           taps_reg, taps_next;
    logic [CFG_W-1:0]           dec_reg, dec_next;
    logic [PW-1:0]              phase_reg, phase_next;
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic signed [OUT_W-1:0]    out_reg, out_next;
    logic                       out_valid_reg, out_valid_next;

    logic [TW-1:0]              t_eff;
    logic [TW-1:0]              t_addr;
    logic [DW-1:0]              d_eff;
    logic [DW-1:0]              ph_inc;
    logic [PW-1:0]              phase_adv;
    logic [IW-1:0]              cidx_ext;
    logic                       accept;

    cell_mode_t                 cmode;
    logic signed [SAMPLE_W-1:0] x_in;
    logic signed [SAMPLE_W-1:0] hist_q [D];

    mac_ctl_t                   mctl;
    logic signed [SAMPLE_W-1:0] mac_sample;
    logic signed [COEF_W-1:0]   coef_rd;
    logic signed [OUT_W-1:0]    mac_result;
    logic                       ram_we;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(32 - OUT_W){1'b0}}, out_reg};

    // effective tap count and decimation after clamping
    always_comb
    begin
        if (taps_reg == '0)
        begin
            t_eff = TW'(1);
        end
        else if (TW'(taps_reg) > TW'(MAX_TAPS))
        begin
            t_eff = TW'(MAX_TAPS);
        end
        else
        begin
            t_eff = TW'(taps_reg);
        end

        if (dec_reg == '0)
        begin
            d_eff = DW'(1);
        end
        else if (DW'(dec_reg) > DW'(MAX_DECIMATION))
        begin
            d_eff = DW'(MAX_DECIMATION);
        end
        else
        begin
            d_eff = DW'(dec_reg);
        end
    end

    assign ph_inc    = DW'(phase_reg) + DW'(1);
    assign phase_adv = (ph_inc >= d_eff) ? '0 : ph_inc[PW-1:0];
    assign t_addr    = t_eff - TW'(1) - TW'(cnt_reg);
    assign cidx_ext  = IW'(coef_index);

    // cell 0 shifts in the incoming sample when idle, the held one after a MAC pass
    assign x_in       = (state_reg == ST_IDLE) ? sample : x_reg;
    assign mac_sample = (cnt_reg == '0) ? x_reg : hist_q[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg <= CFG_W'(1);
            dec_reg  <= CFG_W'(1);
        end
        else
        begin
            taps_reg <= taps_next;
            dec_reg  <= dec_next;
        end
    end

    always_comb
    begin
        taps_next = taps_reg;
        dec_next  = dec_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TAP_COUNT:  taps_next = cfg_data;
                CFG_DECIMATION: dec_next  = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        x_next         = x_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmode          = CM_HOLD;
        ram_we         = 1'b0;
        mctl.clr       = 1'b0;
        mctl.vld       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_t'(req_type))
                        REQ_SAMPLE:
                        begin
                            if (phase_reg == '0)
                            begin
                                x_next     = sample;
                                cnt_next   = '0;
                                mctl.clr   = 1'b1;
                                state_next = ST_MAC;
                            end
                            else
                            begin
                                cmode      = CM_SHIFT;
                                phase_next = phase_adv;
                            end
                        end
                        REQ_COEF:
                        begin
                            ram_we = (cidx_ext < IW'(MAX_TAPS));
                        end
                        REQ_CLEAR:
                        begin
                            cmode      = CM_CLEAR;
                            phase_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MAC:
            begin
                // term 0 is the new sample; term k uses history[k-1] at cell 0
                mctl.vld = (TW'(cnt_reg) < t_eff);
                if (cnt_reg != '0)
                begin
                    cmode = CM_ROTATE;
                end
                if (cnt_reg == AW'(D))
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg == AW'(1))
                begin
                    cnt_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = mac_result;
                    out_valid_next = 1'b1;
                    cmode          = CM_SHIFT;
                    phase_next     = phase_adv;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // history chain: shift moves toward higher index, rotate toward cell 0
    for (genvar i = 0; i < D; i++)
    begin : g_cell
        logic signed [SAMPLE_W-1:0] left_w;
        logic signed [SAMPLE_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = x_in;
        end
        else
        begin : g_mid_l
            assign left_w = hist_q[i-1];
        end

        if (i == D - 1)
        begin : g_last
            assign right_w = hist_q[0];
        end
        else
        begin : g_mid_r
            assign right_w = hist_q[i+1];
        end

        dfir_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .mode     (cmode),
            .left_in  (left_w),
            .right_in (right_w),
            .q        (hist_q[i])
        );
    end

    dfir_coef_ram #(
        .DEPTH (MAX_TAPS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cidx_ext[AW-1:0]),
        .wdata (coef_value),
        .raddr (t_addr[AW-1:0]),
        .rdata (coef_rd)
    );

    dfir_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mctl),
        .sample (mac_sample),
        .coef   (coef_rd),
        .result (mac_result)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !(s_tvalid && s_tready))
        else $error("item accepted while a MAC pass is running");

    a_finish_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && state_next == ST_IDLE) |=> out_valid_reg)
        else $error("result not loaded at end of MAC pass");

    a_drain_after_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC && state_next == ST_DRAIN) |-> (cnt_reg == AW'(D)))
        else $error("MAC pass ended before a full rotation");

endmodule
